// File: rtl/core/trrs_pkg.sv
package trrs_pkg;

    // Ring depth; task ids are fixed at 3 bits by the word format.
    localparam int MAX_TASKS = 8;
    localparam int ID_W      = 3;
    localparam int NUM_IDS   = 1 << ID_W;
    localparam int TIME_W    = 16;
    localparam int TOTAL_W   = 32;
    localparam int Q_W       = 8;
    localparam int PTR_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int SUM_W     = $clog2(2 * MAX_TASKS);

    localparam logic [Q_W-1:0] QUANTUM_RESET = 8'd2;

    // APB register map
    localparam int PADDR_W = 3;
    localparam logic REG_QUANTUM = 1'b0;

    localparam logic MODE_ADMIT    = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        EV_ADMIT   = 3'd0,
        EV_REJECT  = 3'd1,
        EV_FINISH  = 3'd2,
        EV_DEMOTE  = 3'd3,
        EV_REQUEUE = 3'd4,
        EV_IDLE    = 3'd5
    } t_event;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic              mode;
        t_id               task_id;
        logic [TIME_W-1:0] burst_time;
    } t_in_word;

    typedef struct packed {
        t_id                served_id;
        t_event             event_res;
        logic [TIME_W-1:0]  time_left;
        logic [TOTAL_W-1:0] elapsed;
    } t_out_word;

    typedef struct packed {
        logic start;   // word accepted, launch ring head reads
        logic commit;  // apply state update and load result
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_hold;  // result register full and stalled
    } t_dp_status;

    // (head + offset) mod MAX_TASKS, both operands below or at MAX_TASKS
    function automatic t_ptr ring_idx(t_ptr head, t_cnt offset);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(offset);
        if (s >= SUM_W'(MAX_TASKS)) begin
            s = s - SUM_W'(MAX_TASKS);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// File: rtl/core/trrs_ram.sv
module trrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/trrs_ctrl.sv
module trrs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  trrs_pkg::t_dp_status  i_status,
    output logic                  o_in_stall,
    output trrs_pkg::t_ctrl_cmd   o_cmd
);

    trrs_pkg::t_state r_state;
    trrs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            trrs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = trrs_pkg::S_EXEC;
                end
            end
            trrs_pkg::S_EXEC: begin
                if (!i_status.out_hold) begin
                    n_state = trrs_pkg::S_IDLE;
                end
            end
            default: n_state = trrs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd.start  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            trrs_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            trrs_pkg::S_EXEC: begin
                o_cmd.commit = !i_status.out_hold;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// File: rtl/core/trrs_dpath.sv
module trrs_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  trrs_pkg::t_ctrl_cmd            i_cmd,
    input  trrs_pkg::t_in_word             i_in_word,
    input  logic [trrs_pkg::Q_W-1:0]       i_quantum,
    input  logic                           i_out_stall,
    output trrs_pkg::t_dp_status           o_status,
    output logic                           o_out_valid,
    output trrs_pkg::t_out_word            o_out_word
);

    trrs_pkg::t_in_word                 r_item;
    logic [trrs_pkg::TIME_W-1:0]        r_remaining [trrs_pkg::NUM_IDS];
    logic [trrs_pkg::NUM_IDS-1:0]       r_pending;
    trrs_pkg::t_ptr                     r_high_head, r_low_head;
    trrs_pkg::t_cnt                     r_high_count, r_low_count;
    logic [trrs_pkg::TOTAL_W-1:0]       r_time_total;
    logic                               r_out_valid;
    trrs_pkg::t_out_word                r_out_word;

    trrs_pkg::t_ptr                     n_high_head, n_low_head;
    trrs_pkg::t_cnt                     n_high_count, n_low_count;
    logic [trrs_pkg::TOTAL_W-1:0]       n_time_total;
    trrs_pkg::t_out_word                n_out_word;

    trrs_pkg::t_id                      high_rd, low_rd, sel_id;
    logic                               high_wr, low_wr;
    trrs_pkg::t_ptr                     high_wr_addr, low_wr_addr;
    logic                               rem_wr, pend_set, pend_clr;
    trrs_pkg::t_id                      rem_id;
    logic [trrs_pkg::TIME_W-1:0]        rem_data;

    logic                               from_high, from_low;
    logic [trrs_pkg::TIME_W-1:0]        rem_cur, quantum_x, used, rem_new;
    logic [trrs_pkg::TOTAL_W:0]         total_sum;
    logic                               admit_ok;

    trrs_ram #(.WIDTH(trrs_pkg::ID_W), .DEPTH(trrs_pkg::MAX_TASKS)) u_high_ring (
        .i_clk     (i_clk),
        .i_wr_en   (high_wr),
        .i_wr_addr (high_wr_addr),
        .i_wr_data (r_item.task_id),
        .i_rd_en   (i_cmd.start),
        .i_rd_addr (r_high_head),
        .o_rd_data (high_rd)
    );

    trrs_ram #(.WIDTH(trrs_pkg::ID_W), .DEPTH(trrs_pkg::MAX_TASKS)) u_low_ring (
        .i_clk     (i_clk),
        .i_wr_en   (low_wr),
        .i_wr_addr (low_wr_addr),
        .i_wr_data (sel_id),
        .i_rd_en   (i_cmd.start),
        .i_rd_addr (r_low_head),
        .o_rd_data (low_rd)
    );

    assign high_wr_addr = trrs_pkg::ring_idx(r_high_head, r_high_count);
    // pop and push on the same ring land at old head + old count
    assign low_wr_addr  = trrs_pkg::ring_idx(r_low_head, r_low_count);

    assign from_high = (r_high_count != '0) &&
                       (r_low_count != trrs_pkg::CNT_W'(trrs_pkg::MAX_TASKS));
    assign from_low  = !from_high && (r_low_count != '0);
    assign sel_id    = from_high ? high_rd : low_rd;

    assign rem_cur   = r_remaining[sel_id];
    assign quantum_x = trrs_pkg::TIME_W'(i_quantum);
    assign used      = (rem_cur < quantum_x) ? rem_cur : quantum_x;
    assign rem_new   = rem_cur - used;
    assign total_sum = {1'b0, r_time_total} + (trrs_pkg::TOTAL_W + 1)'(used);

    assign admit_ok  = (r_high_count != trrs_pkg::CNT_W'(trrs_pkg::MAX_TASKS)) &&
                       !r_pending[r_item.task_id];

    always_comb begin
        n_high_head  = r_high_head;
        n_high_count = r_high_count;
        n_low_head   = r_low_head;
        n_low_count  = r_low_count;
        n_time_total = r_time_total;
        high_wr      = 1'b0;
        low_wr       = 1'b0;
        rem_wr       = 1'b0;
        rem_id       = r_item.task_id;
        rem_data     = r_item.burst_time;
        pend_set     = 1'b0;
        pend_clr     = 1'b0;
        n_out_word.served_id = r_item.task_id;
        n_out_word.event_res = trrs_pkg::EV_REJECT;
        n_out_word.time_left = '0;
        n_out_word.elapsed   = r_time_total;

        if (r_item.mode == trrs_pkg::MODE_ADMIT) begin
            if (admit_ok) begin
                high_wr      = i_cmd.commit;
                rem_wr       = i_cmd.commit;
                pend_set     = i_cmd.commit;
                n_high_count = r_high_count + trrs_pkg::CNT_W'(1);
                n_out_word.event_res = trrs_pkg::EV_ADMIT;
                n_out_word.time_left = r_item.burst_time;
            end
        end else if (from_high || from_low) begin
            if (from_high) begin
                n_high_head  = trrs_pkg::ring_idx(r_high_head, trrs_pkg::CNT_W'(1));
                n_high_count = r_high_count - trrs_pkg::CNT_W'(1);
            end else begin
                n_low_head  = trrs_pkg::ring_idx(r_low_head, trrs_pkg::CNT_W'(1));
                n_low_count = r_low_count - trrs_pkg::CNT_W'(1);
            end
            rem_wr   = i_cmd.commit;
            rem_id   = sel_id;
            rem_data = rem_new;
            // saturate on carry out of the 32-bit total
            n_time_total = total_sum[trrs_pkg::TOTAL_W] ? '1
                                                        : total_sum[trrs_pkg::TOTAL_W-1:0];
            n_out_word.served_id = sel_id;
            n_out_word.elapsed   = n_time_total;
            if (rem_new == '0) begin
                pend_clr = i_cmd.commit;
                n_out_word.event_res = trrs_pkg::EV_FINISH;
            end else begin
                low_wr      = i_cmd.commit;
                n_low_count = n_low_count + trrs_pkg::CNT_W'(1);
                n_out_word.event_res = from_high ? trrs_pkg::EV_DEMOTE
                                                 : trrs_pkg::EV_REQUEUE;
                n_out_word.time_left = rem_new;
            end
        end else begin
            n_out_word.served_id = '0;
            n_out_word.event_res = trrs_pkg::EV_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_high_head  <= '0;
            r_high_count <= '0;
            r_low_head   <= '0;
            r_low_count  <= '0;
            r_time_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_high_head  <= n_high_head;
                r_high_count <= n_high_count;
                r_low_head   <= n_low_head;
                r_low_count  <= n_low_count;
                r_time_total <= n_time_total;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (pend_set) begin
                r_pending[rem_id] <= 1'b1;
            end
            if (pend_clr) begin
                r_pending[rem_id] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item <= i_in_word;
        end
        if (i_cmd.commit) begin
            r_out_word <= n_out_word;
        end
        if (rem_wr) begin
            r_remaining[rem_id] <= rem_data;
        end
    end

    assign o_status.out_hold = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

endmodule

// File: rtl/core/two_level_round_robin_scheduler.sv
// A word accepted in the idle state launches reads of both ring heads from their
// RAMs; the execute state does the remaining-time read-modify-write and loads the
// result register. No new word is taken until the execute state ends, and a
// stalled result holds the execute state until the result register frees.
// Reset (i_rst_n low, synchronous) empties both rings, clears pending flags
// and elapsed time, and sets quantum to 2. No clearing pass is needed.
module two_level_round_robin_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input word channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  trrs_pkg::t_in_word            i_in_word,
    // result word channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output trrs_pkg::t_out_word           o_out_word,
    // APB configuration port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [trrs_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready
);

    trrs_pkg::t_ctrl_cmd   cmd;
    trrs_pkg::t_dp_status  status;

    // Quantum register; word address 0, anything else reads zero.
    logic [trrs_pkg::Q_W-1:0] r_quantum;
    logic                     reg_sel;

    assign reg_sel  = (i_paddr[2] == trrs_pkg::REG_QUANTUM);
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= trrs_pkg::QUANTUM_RESET;
        end else if (i_psel && i_penable && i_pwrite && reg_sel) begin
            r_quantum <= i_pwdata[trrs_pkg::Q_W-1:0];
        end
    end

    assign o_prdata = reg_sel ? {(32 - trrs_pkg::Q_W)'(0), r_quantum} : 32'd0;

    // Controller: idle/execute sequencing, owns the input stall.
    trrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Datapath: ring RAMs, per-task remaining time, counters, result register.
    trrs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_quantum   (r_quantum),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// File: rtl/core/trrs_chk.sv
module trrs_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  trrs_pkg::t_out_word           o_out_word
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // one word in flight: stall follows every acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted while busy");

    // a new result only comes out of the execute cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an accepted word");

    // elapsed time never goes backwards
    a_elapsed_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid) && o_out_valid |->
            o_out_word.elapsed >= $past(o_out_word.elapsed))
        else $error("elapsed time decreased");

endmodule

bind two_level_round_robin_scheduler trrs_chk u_chk (.*);
